// File: design/atnp_pkg.sv
// Package: shared types, decode constants and a helper function for the next-PC predictor.
`timescale 1ns / 1ps

package atnp_pkg;

  // Register file layout.
  localparam int unsigned NumGpr = 16;
  localparam logic [4:0] PC_IDX = 5'd15;
  localparam logic [4:0] STATUS_IDX = 5'd16;
  localparam int unsigned CarryBit = 29;

  // Command codes of an input transaction.
  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_DECODE = 2'd1;
  localparam logic [1:0] CMD_MEMORY = 2'd2;

  // Result kinds.
  typedef enum logic [1:0] {
    KIND_WRITE  = 2'd0,
    KIND_BRANCH = 2'd1,
    KIND_NONE   = 2'd2,
    KIND_READ   = 2'd3
  } kind_t;

  // ARM data processing opcodes.
  typedef enum logic [3:0] {
    DP_AND = 4'd0,  DP_EOR = 4'd1,  DP_SUB = 4'd2,  DP_RSB = 4'd3,
    DP_ADD = 4'd4,  DP_ADC = 4'd5,  DP_SBC = 4'd6,  DP_RSC = 4'd7,
    DP_TST = 4'd8,  DP_TEQ = 4'd9,  DP_CMP = 4'd10, DP_CMN = 4'd11,
    DP_ORR = 4'd12, DP_MOV = 4'd13, DP_BIC = 4'd14, DP_MVN = 4'd15
  } dp_op_t;

  // Barrel shifter operations.
  typedef enum logic [1:0] {
    SH_LSL = 2'd0,
    SH_LSR = 2'd1,
    SH_ASR = 2'd2,
    SH_ROR = 2'd3
  } shift_t;

  // ARM instruction patterns.
  localparam logic [31:0] ARM_BX_MASK = 32'h0fff_fff0;
  localparam logic [31:0] ARM_BX_CODE = 32'h012f_ff10;
  localparam logic [31:0] ARM_LDR_MASK = 32'h0c10_f000;
  localparam logic [31:0] ARM_LDR_CODE = 32'h0410_f000;
  localparam logic [31:0] ARM_LDM_MASK = 32'h0e10_8000;
  localparam logic [31:0] ARM_LDM_CODE = 32'h0810_8000;

  // Thumb instruction patterns.
  localparam logic [15:0] TH_BX_MASK = 16'hff80;
  localparam logic [15:0] TH_BX_CODE = 16'h4700;
  localparam logic [15:0] TH_HIPC_MASK = 16'hfc87;
  localparam logic [15:0] TH_HIPC_CODE = 16'h4487;
  localparam logic [7:0] TH_POP_PC_CODE = 8'hbd;
  localparam logic [7:0] TH_SWI_CODE = 8'hdf;

  // Hi-register operations with the PC as destination.
  localparam logic [1:0] TH_HI_ADD = 2'd0;
  localparam logic [1:0] TH_HI_MOV = 2'd2;

  typedef logic [NumGpr-1:0][31:0] gpr_t;

  // One input transaction as it sits in the input register.
  typedef struct packed {
    logic [1:0]  cmd;
    logic [4:0]  reg_index;
    logic [31:0] reg_value;
    logic [31:0] instruction;
    logic        thumb;
    logic [31:0] mem_word;
  } item_t;

  // Outstanding load into the PC.
  typedef struct packed {
    logic       pending;
    logic [1:0] rotate;
    logic       is_byte;
  } load_state_t;

  function automatic logic [31:0] ror32(input logic [31:0] v, input logic [4:0] n);
    logic [63:0] d;
    d = {v, v} >> n;
    return d[31:0];
  endfunction

endpackage

// File: design/atnp_if.sv
// Interfaces: valid/ready channels for input and result transactions.
`timescale 1ns / 1ps

interface atnp_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [4:0]  reg_index;
  logic [31:0] reg_value;
  logic [31:0] instruction;
  logic        thumb;
  logic [31:0] mem_word;

  modport source (output valid, cmd, reg_index, reg_value, instruction, thumb, mem_word,
                  input ready);
  modport sink (input valid, cmd, reg_index, reg_value, instruction, thumb, mem_word,
                output ready);
endinterface

interface atnp_out_if;
  logic              valid;
  logic              ready;
  atnp_pkg::kind_t   kind;
  logic [31:0]       target;

  modport source (output valid, kind, target, input ready);
  modport sink (input valid, kind, target, output ready);
endinterface

// File: design/atnp_shifter.sv
// Barrel shifter for the ARM register operand, with immediate and register shift amounts.
`timescale 1ns / 1ps

module atnp_shifter (
  input  logic [31:0] rm_value,
  input  logic [7:0]  shift_spec,  // instruction bits 11..4
  input  logic [7:0]  rs_low,
  input  logic        carry_in,
  output logic [31:0] operand
);

  logic               by_reg;
  atnp_pkg::shift_t   sh_type;
  logic [4:0]         imm_amt;
  logic [7:0]         amt;
  logic               amt_big;

  assign by_reg  = shift_spec[0];
  assign sh_type = atnp_pkg::shift_t'(shift_spec[2:1]);
  assign imm_amt = shift_spec[7:3];

  // An immediate amount of zero means 32 for LSR and ASR, and RRX for ROR.
  always_comb begin
    if (by_reg) begin
      amt = rs_low;
    end else if (imm_amt == 5'd0 && (sh_type == atnp_pkg::SH_LSR ||
                                     sh_type == atnp_pkg::SH_ASR)) begin
      amt = 8'd32;
    end else begin
      amt = {3'b000, imm_amt};
    end
  end

  assign amt_big = (amt[7:5] != 3'b000);

  always_comb begin
    unique case (sh_type)
      atnp_pkg::SH_LSL: operand = amt_big ? 32'h0 : (rm_value << amt[4:0]);
      atnp_pkg::SH_LSR: operand = amt_big ? 32'h0 : (rm_value >> amt[4:0]);
      atnp_pkg::SH_ASR: operand = amt_big ? {32{rm_value[31]}} :
                                  $unsigned($signed(rm_value) >>> amt[4:0]);
      atnp_pkg::SH_ROR: operand = (!by_reg && imm_amt == 5'd0) ?
                                  {carry_in, rm_value[31:1]} :
                                  atnp_pkg::ror32(rm_value, amt[4:0]);
      default:          operand = rm_value;
    endcase
  end

endmodule

// File: design/atnp_decode.sv
// Decoder: computes the result of one transaction from the register file and load state.
`timescale 1ns / 1ps

module atnp_decode (
  input  atnp_pkg::item_t       item,
  input  atnp_pkg::gpr_t        gpr,
  input  logic [31:0]           status,
  input  atnp_pkg::load_state_t load_cur,
  output atnp_pkg::kind_t       kind,
  output logic [31:0]           target,
  output atnp_pkg::load_state_t load_nxt
);

  logic [31:0] instr;
  logic [15:0] t;
  logic [31:0] pc;
  logic        carry;
  logic [3:0]  rn;
  logic [3:0]  rm;
  logic [3:0]  rs;
  logic        rn_is_pc;
  logic        rm_is_pc;
  logic [31:0] rn_val;
  logic [31:0] rm_val;
  logic [31:0] rs_val;
  logic [31:0] sh_in;
  logic [31:0] sh_out;

  // ARM datapath
  logic [31:0] arm_b_tgt;
  logic [31:0] dp_a;
  logic [31:0] dp_b;
  logic [31:0] dp_r;
  logic        dp_valid;
  logic [31:0] ldr_base;
  logic [31:0] ldr_off;
  logic [31:0] ldr_addr;
  logic        ldr_bad;
  logic [4:0]  ldm_n;
  logic [31:0] ldm_addr;

  // Thumb datapath
  logic [3:0]  th_rm;
  logic [31:0] th_m;
  logic [3:0]  pop_n;
  logic [31:0] pop_addr;
  logic [31:0] th_bcond_tgt;
  logic [31:0] th_b_tgt;
  logic [31:0] th_bl_tgt;

  atnp_pkg::kind_t arm_kind;
  logic [31:0]     arm_target;
  logic            arm_load;
  logic            arm_byte;
  logic [1:0]      arm_rot;
  atnp_pkg::kind_t th_kind;
  logic [31:0]     th_target;
  logic [31:0]     mem_rot;

  assign instr = item.instruction;
  assign t     = item.instruction[15:0];
  assign pc    = gpr[4'(atnp_pkg::PC_IDX)];
  assign carry = status[atnp_pkg::CarryBit];

  assign rn = instr[19:16];
  assign rm = instr[3:0];
  assign rs = instr[11:8];
  assign rn_is_pc = (rn == 4'(atnp_pkg::PC_IDX));
  assign rm_is_pc = (rm == 4'(atnp_pkg::PC_IDX));
  assign rn_val = gpr[rn];
  assign rm_val = gpr[rm];
  assign rs_val = gpr[rs];

  // The PC reads two instructions ahead, and one more word with a register shift.
  assign sh_in = rm_val + (rm_is_pc ? (instr[4] ? 32'd12 : 32'd8) : 32'd0);

  atnp_shifter u_shifter (
    .rm_value   (sh_in),
    .shift_spec (instr[11:4]),
    .rs_low     (rs_val[7:0]),
    .carry_in   (carry),
    .operand    (sh_out)
  );

  assign arm_b_tgt = (pc + {{6{instr[23]}}, instr[23:0], 2'b00} + 32'd8) & ~32'd1;

  assign dp_a = rn_val + (rn_is_pc ? ((!instr[25] && instr[4]) ? 32'd12 : 32'd8) : 32'd0);
  assign dp_b = instr[25] ? atnp_pkg::ror32({24'h0, instr[7:0]}, {instr[11:8], 1'b0})
                          : sh_out;

  always_comb begin
    dp_valid = 1'b1;
    unique case (atnp_pkg::dp_op_t'(instr[24:21]))
      atnp_pkg::DP_AND: dp_r = dp_a & dp_b;
      atnp_pkg::DP_EOR: dp_r = dp_a ^ dp_b;
      atnp_pkg::DP_SUB: dp_r = dp_a - dp_b;
      atnp_pkg::DP_RSB: dp_r = dp_b - dp_a;
      atnp_pkg::DP_ADD: dp_r = dp_a + dp_b;
      atnp_pkg::DP_ADC: dp_r = dp_a + dp_b + {31'h0, carry};
      atnp_pkg::DP_SBC: dp_r = dp_a - dp_b + {31'h0, carry} - 32'd1;
      atnp_pkg::DP_RSC: dp_r = dp_b - dp_a + {31'h0, carry} - 32'd1;
      atnp_pkg::DP_ORR: dp_r = dp_a | dp_b;
      atnp_pkg::DP_MOV: dp_r = dp_b;
      atnp_pkg::DP_BIC: dp_r = dp_a & ~dp_b;
      atnp_pkg::DP_MVN: dp_r = ~dp_b;
      default: begin
        // Compare and test forms do not write the PC.
        dp_r     = 32'h0;
        dp_valid = 1'b0;
      end
    endcase
  end

  // Single data load: post-indexed forms use the unmodified base.
  assign ldr_base = rn_val + (rn_is_pc ? 32'd8 : 32'd0);
  assign ldr_off  = !instr[24] ? 32'h0 : (instr[25] ? sh_out : {20'h0, instr[11:0]});
  assign ldr_addr = instr[23] ? (ldr_base + ldr_off) : (ldr_base - ldr_off);
  assign ldr_bad  = instr[24] && instr[25] && (rm_is_pc || instr[4]);

  // Block load: the PC is the highest slot of the transfer.
  assign ldm_n    = 5'($countones(instr[14:0])) + {4'h0, instr[24]};
  assign ldm_addr = instr[23] ? (rn_val + {25'h0, ldm_n, 2'b00}) :
                    (instr[24] ? (rn_val - 32'd4) : rn_val);

  always_comb begin
    arm_kind   = atnp_pkg::KIND_NONE;
    arm_target = 32'h0;
    arm_load   = 1'b0;
    arm_byte   = 1'b0;
    arm_rot    = 2'b00;
    priority if (instr[27:25] == 3'b101) begin
      arm_kind   = atnp_pkg::KIND_BRANCH;
      arm_target = arm_b_tgt;
    end else if ((instr & atnp_pkg::ARM_BX_MASK) == atnp_pkg::ARM_BX_CODE) begin
      arm_kind   = atnp_pkg::KIND_BRANCH;
      arm_target = rm_val;
    end else if (instr[27:24] == 4'hf) begin
      arm_kind = atnp_pkg::KIND_NONE;
    end else if (instr[27:26] == 2'b00 && instr[15:12] == 4'(atnp_pkg::PC_IDX)) begin
      if (dp_valid) begin
        arm_kind   = atnp_pkg::KIND_BRANCH;
        arm_target = dp_r & ~32'd1;
      end
    end else if ((instr & atnp_pkg::ARM_LDR_MASK) == atnp_pkg::ARM_LDR_CODE) begin
      if (!ldr_bad) begin
        arm_kind   = atnp_pkg::KIND_READ;
        arm_target = ldr_addr & ~32'd3;
        arm_load   = 1'b1;
        arm_rot    = ldr_addr[1:0];
        arm_byte   = instr[22];
      end
    end else if ((instr & atnp_pkg::ARM_LDM_MASK) == atnp_pkg::ARM_LDM_CODE) begin
      if (!rn_is_pc) begin
        arm_kind   = atnp_pkg::KIND_READ;
        arm_target = ldm_addr & ~32'd3;
        arm_load   = 1'b1;
      end
    end else begin
      arm_kind = atnp_pkg::KIND_NONE;
    end
  end

  // Thumb: the PC reads one instruction pair ahead.
  assign th_rm = t[6:3];
  assign th_m  = gpr[th_rm] + ((th_rm == 4'(atnp_pkg::PC_IDX)) ? 32'd4 : 32'd0);
  assign pop_n = 4'($countones(t[7:0]));
  assign pop_addr = gpr[13] + {26'h0, pop_n, 2'b00};
  assign th_bcond_tgt = (pc + {{23{t[7]}}, t[7:0], 1'b0} + 32'd4) | 32'd1;
  assign th_b_tgt     = (pc + {{20{t[10]}}, t[10:0], 1'b0} + 32'd4) | 32'd1;
  assign th_bl_tgt    = (gpr[14] + {20'h0, t[10:0], 1'b0}) | 32'd1;

  always_comb begin
    th_kind   = atnp_pkg::KIND_NONE;
    th_target = 32'h0;
    priority if ((t & atnp_pkg::TH_BX_MASK) == atnp_pkg::TH_BX_CODE) begin
      th_kind   = atnp_pkg::KIND_BRANCH;
      th_target = th_m;
    end else if ((t & atnp_pkg::TH_HIPC_MASK) == atnp_pkg::TH_HIPC_CODE) begin
      if (t[9:8] == atnp_pkg::TH_HI_ADD) begin
        th_kind   = atnp_pkg::KIND_BRANCH;
        th_target = (th_m + pc + 32'd4) | 32'd1;
      end else if (t[9:8] == atnp_pkg::TH_HI_MOV) begin
        th_kind   = atnp_pkg::KIND_BRANCH;
        th_target = th_m | 32'd1;
      end
    end else if (t[15:8] == atnp_pkg::TH_POP_PC_CODE) begin
      th_kind   = atnp_pkg::KIND_READ;
      th_target = pop_addr & ~32'd3;
    end else if (t[15:12] == 4'hd && t[11:8] != 4'hf) begin
      th_kind   = atnp_pkg::KIND_BRANCH;
      th_target = th_bcond_tgt;
    end else if (t[15:8] == atnp_pkg::TH_SWI_CODE) begin
      th_kind = atnp_pkg::KIND_NONE;
    end else if (t[15:11] == 5'b11100) begin
      th_kind   = atnp_pkg::KIND_BRANCH;
      th_target = th_b_tgt;
    end else if (t[15:11] == 5'b11111) begin
      th_kind   = atnp_pkg::KIND_BRANCH;
      th_target = th_bl_tgt;
    end else begin
      th_kind = atnp_pkg::KIND_NONE;
    end
  end

  assign mem_rot = atnp_pkg::ror32(item.mem_word, {load_cur.rotate, 3'b000});

  always_comb begin
    kind     = atnp_pkg::KIND_NONE;
    target   = 32'h0;
    load_nxt = load_cur;
    unique case (item.cmd)
      atnp_pkg::CMD_WRITE: begin
        kind = atnp_pkg::KIND_WRITE;
      end
      atnp_pkg::CMD_DECODE: begin
        // A new decode drops any load still waiting for its word.
        load_nxt = '0;
        if (item.thumb) begin
          kind   = th_kind;
          target = th_target;
          load_nxt.pending = (th_kind == atnp_pkg::KIND_READ);
        end else begin
          kind   = arm_kind;
          target = arm_target;
          load_nxt.pending = arm_load;
          load_nxt.rotate  = arm_rot;
          load_nxt.is_byte = arm_byte;
        end
      end
      atnp_pkg::CMD_MEMORY: begin
        if (load_cur.pending) begin
          kind     = atnp_pkg::KIND_BRANCH;
          target   = load_cur.is_byte ? {24'h0, mem_rot[7:0]} : mem_rot;
          load_nxt = '0;
        end
      end
      default: begin
        kind = atnp_pkg::KIND_NONE;
      end
    endcase
  end

endmodule

// File: design/arm_thumb_next_pc_predictor.sv
// Top level: next-PC predictor with register file, input register and result register.
`timescale 1ns / 1ps

//  Channel   Direction  Payload                                              Handshake
//  in_ch     sink       cmd, reg_index, reg_value, instruction, thumb,       valid/ready
//                       mem_word
//  out_ch    source     kind, target                                         valid/ready
//
// An accepted transaction sits in the input register while it is decoded; the edge on
// which it moves on loads the result register and updates the register file, so the
// result is valid after that edge and held in the result register until out_ch takes it.
// One transaction per cycle is sustained while out_ch.ready holds; the decoder, barrel
// shifter and adders between the two registers set the clock, not the rate.
// Reset (synchronous, active low) clears the register file, the pending load and
// both valid flags. A stalled result holds in the result register while the input
// register keeps one more transaction; in_ch.ready drops only when both are full.

module arm_thumb_next_pc_predictor (
  input  logic           clk,
  input  logic           rst_n,
  atnp_in_if.sink        in_ch,
  atnp_out_if.source     out_ch
);

  // Input register.
  logic                  s1_valid_r;
  atnp_pkg::item_t       s1_item_r;

  // Architectural state.
  atnp_pkg::gpr_t        gpr_r;
  logic [31:0]           status_r;
  atnp_pkg::load_state_t load_r;
  atnp_pkg::load_state_t load_nxt;

  // Result register.
  logic                  out_valid_r;
  atnp_pkg::kind_t       out_kind_r;
  logic [31:0]           out_target_r;

  atnp_pkg::kind_t       dec_kind;
  logic [31:0]           dec_target;
  logic                  advance;
  logic                  in_take;

  // The item in the input register moves on whenever the result register is
  // empty or is being emptied in this cycle. All state updates happen on that
  // move, so items see the register file strictly in arrival order.
  assign advance   = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || advance;
  assign in_take   = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_take) begin
      s1_valid_r <= 1'b1;
    end else if (advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_item_r.cmd         <= in_ch.cmd;
      s1_item_r.reg_index   <= in_ch.reg_index;
      s1_item_r.reg_value   <= in_ch.reg_value;
      s1_item_r.instruction <= in_ch.instruction;
      s1_item_r.thumb       <= in_ch.thumb;
      s1_item_r.mem_word    <= in_ch.mem_word;
    end
  end

  atnp_decode u_decode (
    .item     (s1_item_r),
    .gpr      (gpr_r),
    .status   (status_r),
    .load_cur (load_r),
    .kind     (dec_kind),
    .target   (dec_target),
    .load_nxt (load_nxt)
  );

  // Register file writes; an index beyond the status word is ignored but still
  // answered with a write-done result by the decoder.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gpr_r    <= '0;
      status_r <= 32'h0;
      load_r   <= '0;
    end else if (advance) begin
      load_r <= load_nxt;
      if (s1_item_r.cmd == atnp_pkg::CMD_WRITE) begin
        if (s1_item_r.reg_index < atnp_pkg::STATUS_IDX) begin
          gpr_r[s1_item_r.reg_index[3:0]] <= s1_item_r.reg_value;
        end else if (s1_item_r.reg_index == atnp_pkg::STATUS_IDX) begin
          status_r <= s1_item_r.reg_value;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_kind_r   <= dec_kind;
      out_target_r <= dec_target;
    end
  end

  assign out_ch.valid  = out_valid_r;
  assign out_ch.kind   = out_kind_r;
  assign out_ch.target = out_target_r;

endmodule
